@@ design/rfk_pkg.sv @@
// shared constants, types and note table for the finger-key to midi note block
`timescale 1ns / 1ps
package rfk_pkg;

  localparam int unsigned Channels  = 8;
  localparam int unsigned ChW       = 3;
  localparam int unsigned MvW       = 12;
  localparam int unsigned RefW      = 13;
  localparam int unsigned ThrW      = 13;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned MidiChW   = 4;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned SumW      = 17;
  localparam int unsigned BaseW     = 13;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  // calibration frames per baseline update, a power of two
  localparam int unsigned CalFrames = 16;
  localparam int unsigned CalShift  = $clog2(CalFrames);
  localparam int unsigned CalCntW   = (CalFrames > 1) ? $clog2(CalFrames) : 1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ON_THR    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_THR   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_NOTE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VELOCITY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIDI_CH   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DET_MASK  = 3'd5;

  // register reset values
  localparam logic [ThrW-1:0]    RST_ON_THR    = 13'd250;
  localparam logic [ThrW-1:0]    RST_OFF_THR   = 13'd150;
  localparam logic [NoteW-1:0]   RST_BASE_NOTE = 7'd60;
  localparam logic [VelW-1:0]    RST_VELOCITY  = 7'd100;
  localparam logic [MidiChW-1:0] RST_MIDI_CH   = 4'd0;
  localparam logic [MaskW-1:0]   RST_DET_MASK  = 8'd255;

  localparam logic [NoteW-1:0]   NOTE_MAX      = 7'd127;

  // semitone steps of the major scale, element i is degree i
  localparam logic [7:0][3:0] MAJOR_STEPS = {4'd12, 4'd11, 4'd9, 4'd7,
                                             4'd5,  4'd4,  4'd2, 4'd0};

  // one frame-end action for the message side
  typedef struct packed {
    logic               has_off;
    logic [NoteW-1:0]   off_note;
    logic               has_on;
    logic [NoteW-1:0]   on_note;
    logic [Channels-1:0] flags;
  } ev_t;

  // semitone offset of scale degree d (0..14) over two octaves
  function automatic logic [4:0] degree_offset(input logic [3:0] d);
    logic [2:0] idx;
    logic [4:0] oct;
    if (d >= 4'd14) begin
      idx = 3'(d - 4'd14);
      oct = 5'd24;
    end else if (d >= 4'd7) begin
      idx = 3'(d - 4'd7);
      oct = 5'd12;
    end else begin
      idx = d[2:0];
      oct = 5'd0;
    end
    return 5'(MAJOR_STEPS[idx]) + oct;
  endfunction

endpackage

@@ design/rfk_front.sv @@
// front pipeline: reflect level, calibration, key hysteresis and note selection
`timescale 1ns / 1ps
module rfk_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          func_i,
  input  logic [rfk_pkg::ChW-1:0]       channel_i,
  input  logic [rfk_pkg::MvW-1:0]       off_before_mv_i,
  input  logic [rfk_pkg::MvW-1:0]       lit_mv_i,
  input  logic [rfk_pkg::MvW-1:0]       off_after_mv_i,
  input  logic                          frame_end_i,
  input  logic [rfk_pkg::ThrW-1:0]      on_thr_i,
  input  logic [rfk_pkg::ThrW-1:0]      off_thr_i,
  input  logic [rfk_pkg::NoteW-1:0]     base_note_i,
  input  logic [rfk_pkg::MaskW-1:0]     det_mask_i,
  input  logic                          ev_full_i,
  output logic                          ev_push_o,
  output rfk_pkg::ev_t                  ev_o,
  output logic                          ready_o
);
  import rfk_pkg::*;

  logic adv;

  // stage a: reflect level
  logic                   a_valid_q;
  logic                   a_func_q;
  logic [ChW-1:0]         a_ch_q;
  logic signed [RefW-1:0] a_refl_q;
  logic                   a_fend_q;
  logic [MvW:0]           dark_sum;
  logic signed [RefW-1:0] refl_d;

  assign dark_sum = {1'b0, off_before_mv_i} + {1'b0, off_after_mv_i};
  assign refl_d   = $signed({1'b0, dark_sum[MvW:1]}) - $signed({1'b0, lit_mv_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      a_func_q <= func_i;
      a_ch_q   <= channel_i;
      a_refl_q <= refl_d;
      a_fend_q <= frame_end_i;
    end
  end

  // stage b: calibration sums and key flags
  logic signed [SumW-1:0]  cal_sum_q [Channels];
  logic signed [SumW-1:0]  cal_sum_d [Channels];
  logic signed [BaseW-1:0] base_q    [Channels];
  logic signed [BaseW-1:0] base_d    [Channels];
  logic [CalCntW-1:0]      cal_cnt_q, cal_cnt_d;
  logic [Channels-1:0]     key_q, key_d;
  logic signed [SumW:0]    sum_ext;
  logic signed [SumW-1:0]  sum_sat;
  logic signed [BaseW:0]   lvl_raw;
  logic [BaseW-1:0]        lvl;
  logic                    b_take;

  assign b_take = adv && a_valid_q;

  // sum saturates to the 17-bit signed range
  always_comb begin
    sum_ext = (SumW+1)'(cal_sum_q[a_ch_q]) + (SumW+1)'(a_refl_q);
    if (sum_ext > (SumW+1)'($signed({2'b00, {(SumW-1){1'b1}}}))) begin
      sum_sat = {1'b0, {(SumW-1){1'b1}}};
    end else if (sum_ext < $signed({2'b11, {(SumW-1){1'b0}}})) begin
      sum_sat = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  // level above baseline, clamped at zero
  always_comb begin
    lvl_raw = (BaseW+1)'(a_refl_q) - (BaseW+1)'(base_q[a_ch_q]);
    lvl     = lvl_raw[BaseW] ? '0 : lvl_raw[BaseW-1:0];
  end

  always_comb begin
    logic signed [SumW-1:0] v;
    logic [SumW-1:0]        mag;
    logic [SumW-1:0]        quo;
    logic signed [SumW:0]   sq;
    cal_sum_d = cal_sum_q;
    base_d    = base_q;
    cal_cnt_d = cal_cnt_q;
    key_d     = key_q;
    v         = '0;
    mag       = '0;
    quo       = '0;
    sq        = '0;
    if (a_func_q) begin
      cal_sum_d[a_ch_q] = sum_sat;
      if (a_fend_q) begin
        cal_cnt_d = cal_cnt_q + 1'b1;
        if (cal_cnt_q == CalCntW'(CalFrames - 1)) begin
          cal_cnt_d = '0;
          for (int i = 0; i < Channels; i++) begin
            v   = (ChW'(i) == a_ch_q) ? sum_sat : cal_sum_q[i];
            // divide toward zero
            mag = v[SumW-1] ? SumW'(-v) : v;
            quo = mag >> CalShift;
            sq  = v[SumW-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
            if (sq > (SumW+1)'($signed({1'b0, {(BaseW-1){1'b1}}}))) begin
              base_d[i] = {1'b0, {(BaseW-1){1'b1}}};
            end else if (sq < -(SumW+1)'($signed({1'b0, 1'b1, {(BaseW-1){1'b0}}}))) begin
              base_d[i] = {1'b1, {(BaseW-1){1'b0}}};
            end else begin
              base_d[i] = sq[BaseW-1:0];
            end
            cal_sum_d[i] = '0;
          end
        end
      end
    end else if (det_mask_i[a_ch_q]) begin
      // on test first, it wins on overlapping thresholds
      if (lvl > on_thr_i) begin
        key_d[a_ch_q] = 1'b1;
      end else if (lvl < off_thr_i) begin
        key_d[a_ch_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        cal_sum_q[i] <= '0;
        base_q[i]    <= '0;
      end
      cal_cnt_q <= '0;
      key_q     <= '0;
    end else if (b_take) begin
      cal_sum_q <= cal_sum_d;
      base_q    <= base_d;
      cal_cnt_q <= cal_cnt_d;
      key_q     <= key_d;
    end
  end

  // stage c: note choice at the end of a measure frame
  logic                c_valid_q;
  logic [Channels-1:0] c_flags_q;
  logic                snd_valid_q;
  logic [NoteW-1:0]    snd_note_q;
  logic [3:0]          key_val;
  logic [4:0]          offs;
  logic signed [NoteW+1:0] n_raw;
  logic [NoteW-1:0]    note_sel;
  logic                need_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= a_valid_q && !a_func_q && a_fend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_take) begin
      c_flags_q <= key_d;
    end
  end

  assign key_val = {c_flags_q[1], c_flags_q[3], c_flags_q[5], c_flags_q[7]};
  assign offs    = degree_offset(key_val - 4'd1);

  // sharp on key 4 released, flat on key 6 released
  always_comb begin
    n_raw = $signed({2'b00, base_note_i}) + $signed({4'b0000, offs})
          + $signed({{(NoteW+1){1'b0}}, !c_flags_q[4]})
          - $signed({{(NoteW+1){1'b0}}, !c_flags_q[6]});
    if (n_raw < 0) begin
      note_sel = '0;
    end else if (n_raw > $signed({2'b00, NOTE_MAX})) begin
      note_sel = NOTE_MAX;
    end else begin
      note_sel = n_raw[NoteW-1:0];
    end
  end

  always_comb begin
    if (key_val == 4'd0) begin
      need_push = snd_valid_q;
    end else begin
      need_push = !(snd_valid_q && (note_sel == snd_note_q));
    end
  end

  assign adv       = !(c_valid_q && need_push && ev_full_i);
  assign ready_o   = adv;
  assign ev_push_o = c_valid_q && need_push && adv;

  always_comb begin
    ev_o.has_off  = snd_valid_q;
    ev_o.off_note = snd_note_q;
    ev_o.has_on   = (key_val != 4'd0);
    ev_o.on_note  = note_sel;
    ev_o.flags    = c_flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snd_valid_q <= 1'b0;
      snd_note_q  <= '0;
    end else if (ev_push_o) begin
      snd_valid_q <= ev_o.has_on;
      snd_note_q  <= ev_o.has_on ? note_sel : '0;
    end
  end

endmodule

@@ design/rfk_fifo.sv @@
// small queue of frame-end actions between the front and the message side
`timescale 1ns / 1ps
module rfk_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  rfk_pkg::ev_t data_i,
  input  logic         rd_i,
  output rfk_pkg::ev_t data_o,
  output logic         full_o,
  output logic         empty_o
);
  import rfk_pkg::*;

  ev_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/rfk_back.sv @@
// message side: expands one action into a note-off and/or note-on request
`timescale 1ns / 1ps
module rfk_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfk_pkg::ev_t                  ev_i,
  input  logic                          ev_empty_i,
  output logic                          ev_pop_o,
  input  logic [rfk_pkg::MidiChW-1:0]   midi_ch_i,
  input  logic [rfk_pkg::VelW-1:0]      velocity_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic                          event_kind_o,
  output logic [rfk_pkg::MidiChW-1:0]   out_channel_o,
  output logic [rfk_pkg::NoteW-1:0]     note_o,
  output logic [rfk_pkg::VelW-1:0]      velocity_o,
  output logic [rfk_pkg::Channels-1:0]  key_flags_o,
  output logic                          last_o
);
  import rfk_pkg::*;

  ev_t  cur_q;
  logic cur_valid_q;
  logic off_done_q;
  logic show_off;
  logic take;
  logic finish;
  logic load;

  assign show_off = cur_q.has_off && !off_done_q;
  assign take     = cur_valid_q && pop_i;
  assign finish   = take && !(show_off && cur_q.has_on);
  assign load     = !cur_valid_q || finish;
  assign ev_pop_o = load && !ev_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      off_done_q  <= 1'b0;
    end else if (load) begin
      cur_valid_q <= !ev_empty_i;
      off_done_q  <= 1'b0;
    end else if (take) begin
      off_done_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_pop_o) begin
      cur_q <= ev_i;
    end
  end

  assign empty_o       = !cur_valid_q;
  assign event_kind_o  = !show_off;
  assign out_channel_o = midi_ch_i;
  assign note_o        = show_off ? cur_q.off_note : cur_q.on_note;
  assign velocity_o    = show_off ? '0 : velocity_i;
  assign key_flags_o   = cur_q.flags;
  assign last_o        = show_off ? !cur_q.has_on : 1'b1;

endmodule

@@ design/reflect_finger_keys_to_midi_note.sv @@
// top level: finger-key reflection sensors to midi note-on / note-off requests
//
//   channel   handshake      payload
//   -------   ------------   ----------------------------------------------------
//   input     push / full    func, channel, off_before_mv, lit_mv, off_after_mv,
//                            frame_end
//   result    empty / pop    event_kind, out_channel, note, velocity, key_flags,
//                            last
//   config    cfg_we_i       cfg_idx_i selects the register, cfg_data_i the value
//
// one input request is taken per cycle while full is low; the front is a
//   three-stage pipeline (reflect level, calibration / hysteresis, note choice)
// a note-changing frame end is registered in stages a and c, the queue and the
//   message side before it shows; a note change takes two pops, one per message
// reset clears key flags, baselines, calibration sums and the sounding note, and
//   loads the register defaults; no clearing pass is needed
// a stalled result side fills the four-entry action queue, then full rises and
//   the front holds; a request with no message passes the note stage unchecked
`timescale 1ns / 1ps
module reflect_finger_keys_to_midi_note (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            func_i,
  input  logic [rfk_pkg::ChW-1:0]         channel_i,
  input  logic [rfk_pkg::MvW-1:0]         off_before_mv_i,
  input  logic [rfk_pkg::MvW-1:0]         lit_mv_i,
  input  logic [rfk_pkg::MvW-1:0]         off_after_mv_i,
  input  logic                            frame_end_i,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic                            event_kind_o,
  output logic [rfk_pkg::MidiChW-1:0]     out_channel_o,
  output logic [rfk_pkg::NoteW-1:0]       note_o,
  output logic [rfk_pkg::VelW-1:0]        velocity_o,
  output logic [rfk_pkg::Channels-1:0]    key_flags_o,
  output logic                            last_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [rfk_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rfk_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rfk_pkg::*;

  // configuration registers
  logic [ThrW-1:0]    on_thr_q;
  logic [ThrW-1:0]    off_thr_q;
  logic [NoteW-1:0]   base_note_q;
  logic [VelW-1:0]    velocity_q;
  logic [MidiChW-1:0] midi_ch_q;
  logic [MaskW-1:0]   det_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q    <= RST_ON_THR;
      off_thr_q   <= RST_OFF_THR;
      base_note_q <= RST_BASE_NOTE;
      velocity_q  <= RST_VELOCITY;
      midi_ch_q   <= RST_MIDI_CH;
      det_mask_q  <= RST_DET_MASK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ON_THR:    on_thr_q    <= cfg_data_i[ThrW-1:0];
        CFG_OFF_THR:   off_thr_q   <= cfg_data_i[ThrW-1:0];
        CFG_BASE_NOTE: base_note_q <= cfg_data_i[NoteW-1:0];
        CFG_VELOCITY:  velocity_q  <= cfg_data_i[VelW-1:0];
        CFG_MIDI_CH:   midi_ch_q   <= cfg_data_i[MidiChW-1:0];
        CFG_DET_MASK:  det_mask_q  <= cfg_data_i[MaskW-1:0];
        default: ; // unused indexes are ignored
      endcase
    end
  end

  // front to back action queue
  ev_t  ev_in;
  ev_t  ev_out;
  logic ev_push;
  logic ev_pop;
  logic ev_full;
  logic ev_empty;
  logic front_ready;

  // the front holds whenever a pending action finds the queue full
  assign full = !front_ready;

  rfk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (push && front_ready),
    .func_i          (func_i),
    .channel_i       (channel_i),
    .off_before_mv_i (off_before_mv_i),
    .lit_mv_i        (lit_mv_i),
    .off_after_mv_i  (off_after_mv_i),
    .frame_end_i     (frame_end_i),
    .on_thr_i        (on_thr_q),
    .off_thr_i       (off_thr_q),
    .base_note_i     (base_note_q),
    .det_mask_i      (det_mask_q),
    .ev_full_i       (ev_full),
    .ev_push_o       (ev_push),
    .ev_o            (ev_in),
    .ready_o         (front_ready)
  );

  rfk_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ev_push),
    .data_i  (ev_in),
    .rd_i    (ev_pop),
    .data_o  (ev_out),
    .full_o  (ev_full),
    .empty_o (ev_empty)
  );

  // message side holds the request shown on the result ports
  rfk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_i          (ev_out),
    .ev_empty_i    (ev_empty),
    .ev_pop_o      (ev_pop),
    .midi_ch_i     (midi_ch_q),
    .velocity_i    (velocity_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .event_kind_o  (event_kind_o),
    .out_channel_o (out_channel_o),
    .note_o        (note_o),
    .velocity_o    (velocity_o),
    .key_flags_o   (key_flags_o),
    .last_o        (last_o)
  );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the finger-key reflection to midi note block
`timescale 1ns / 1ps
module testbench;
  import rfk_pkg::*;

  // input request operation and result message kind
  typedef enum logic {FN_MEASURE = 1'b0, FN_CAL = 1'b1} func_e;
  typedef enum logic {MSG_OFF = 1'b0, MSG_ON = 1'b1} kind_e;

  // one sensor reading request, readings in millivolts
  typedef struct packed {
    func_e fn;
    int    ch;
    int    bef;
    int    lit;
    int    aft;
    bit    fend;
  } sample_t;

  // one midi message as the result side shows it
  typedef struct packed {
    kind_e kind;
    int    chan;
    int    note;
    int    vel;
    int    flags;
    bit    last;
  } msg_t;

  // directed row: typed == 1 means the message count (0 or 1) and the single
  // message are written in the row; otherwise the note tracker decides
  typedef struct packed {
    sample_t s;
    bit      typed;
    int      n;
    kind_e   kind;
    int      note;
    int      flags;
  } row_t;

  localparam int StallLimit = 3000;   // cycles with no handshake or register write
  localparam int HoldCycles = 400;    // one long result-side stall
  localparam int NumRows    = 22;
  localparam int ScaleSemis [8] = '{0, 2, 4, 5, 7, 9, 11, 12};

  // directed part, all at the register defaults (on 250, off 150, base 60)
  localparam row_t StimTable [NumRows] = '{
    // rest at a frame end with nothing sounding, all readings zero
    '{'{FN_MEASURE, 0, 0, 0, 0, 1'b1}, 1'b1, 0, MSG_OFF, 0, 0},
    // key 7 alone at full reflect: degree zero, note-on of the base note
    '{'{FN_MEASURE, 7, 3300, 0, 3300, 1'b1}, 1'b1, 1, MSG_ON, 60, 'h80},
    // same note again: no message
    '{'{FN_MEASURE, 7, 3300, 0, 3300, 1'b1}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 4, 3300, 0, 3300, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // flat from key 6 off: note-off then note-on
    '{'{FN_MEASURE, 7, 3300, 0, 3300, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 6, 3300, 0, 3300, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 1, 3300, 0, 3300, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 3, 3300, 0, 3300, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // all four note keys: top of the two octaves
    '{'{FN_MEASURE, 5, 3300, 0, 3300, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0},
    // calibration requests never give a message
    '{'{FN_CAL, 2, 3300, 0, 3300, 1'b1}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_CAL, 5, 0, 3300, 0, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // hysteresis edges on channel 0: at on level holds, one above turns on
    '{'{FN_MEASURE, 0, 250, 0, 250, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 0, 251, 0, 252, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // at off level holds, odd sum rounds down to one below and turns off
    '{'{FN_MEASURE, 0, 150, 0, 150, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 0, 150, 0, 149, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // negative reflect clamps to zero and clears the note keys
    '{'{FN_MEASURE, 1, 0, 3300, 0, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 3, 0, 3300, 0, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 5, 0, 3300, 0, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // rest while sounding: one note-off
    '{'{FN_MEASURE, 7, 0, 3300, 0, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 4, 0, 3300, 0, 1'b1}, 1'b1, 0, MSG_OFF, 0, 0},
    '{'{FN_MEASURE, 2, 3300, 3300, 3300, 1'b0}, 1'b1, 0, MSG_OFF, 0, 0},
    // sharp from key 4 off with key 6 on
    '{'{FN_MEASURE, 7, 3300, 0, 3300, 1'b1}, 1'b0, 0, MSG_OFF, 0, 0}
  };

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                push            = 1'b0;
  logic                full;
  logic                func_i          = 1'b0;
  logic [ChW-1:0]      channel_i       = '0;
  logic [MvW-1:0]      off_before_mv_i = '0;
  logic [MvW-1:0]      lit_mv_i        = '0;
  logic [MvW-1:0]      off_after_mv_i  = '0;
  logic                frame_end_i     = 1'b0;
  logic                empty;
  logic                pop             = 1'b0;
  logic                event_kind_o;
  logic [MidiChW-1:0]  out_channel_o;
  logic [NoteW-1:0]    note_o;
  logic [VelW-1:0]     velocity_o;
  logic [Channels-1:0] key_flags_o;
  logic                last_o;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  // register mirror
  int thr_on, thr_off, base_nt, vel_cfg, mchan, det_mask;
  // key and calibration state mirror
  bit [7:0] keys;
  int       base_lvl [8];
  int       cal_acc [8];
  int       cal_frames_seen;
  bit       sounding;
  int       sounding_nt;

  msg_t midi_due_q [$];     // messages still owed by the block, oldest first
  int   mismatches  = 0;
  int   sent        = 0;    // accepted input requests
  int   idle_cycles = 0;
  bit   no_idle     = 1'b0; // both sides run flat out while set
  bit   hold_req    = 1'b0; // asks the result side for its long stall
  bit   hold_done   = 1'b0;

  reflect_finger_keys_to_midi_note u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .channel_i      (channel_i),
    .off_before_mv_i(off_before_mv_i),
    .lit_mv_i       (lit_mv_i),
    .off_after_mv_i (off_after_mv_i),
    .frame_end_i    (frame_end_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .out_channel_o  (out_channel_o),
    .note_o         (note_o),
    .velocity_o     (velocity_o),
    .key_flags_o    (key_flags_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // message as the block should build it from the current mirror
  function automatic msg_t midi_msg(input kind_e k, input int nt, input bit lst);
    msg_t m;
    m.kind  = k;
    m.chan  = mchan;
    m.note  = nt;
    m.vel   = (k == MSG_ON) ? vel_cfg : 0;
    m.flags = int'(keys);
    m.last  = lst;
    return m;
  endfunction

  // note tracker: advances the mirror by one accepted request and, with
  // keep set, queues the messages that request owes
  task automatic track_sample(input sample_t s, input bit keep);
    int lvl, r, code, deg, nt;
    lvl = (s.bef + s.aft) / 2 - s.lit;
    if (s.fn == FN_CAL) begin
      // calibration sums saturate; baseline is the mean truncated toward zero
      cal_acc[s.ch] = clampi(cal_acc[s.ch] + lvl, -65536, 65535);
      if (s.fend) begin
        cal_frames_seen++;
        if (cal_frames_seen >= int'(CalFrames)) begin
          for (int i = 0; i < 8; i++) begin
            base_lvl[i] = clampi(cal_acc[i] / int'(CalFrames), -4096, 4095);
            cal_acc[i]  = 0;
          end
          cal_frames_seen = 0;
        end
      end
      return;
    end
    if (((det_mask >> s.ch) & 1) != 0) begin
      r = lvl - base_lvl[s.ch];
      if (r < 0) r = 0;
      // on test first, so overlapping thresholds favor on
      if (r > thr_on) keys[s.ch] = 1'b1;
      else if (r < thr_off) keys[s.ch] = 1'b0;
    end
    if (!s.fend) return;
    code = int'(keys[7]) + 2 * int'(keys[5]) + 4 * int'(keys[3]) + 8 * int'(keys[1]);
    if (code == 0) begin
      if (sounding) begin
        if (keep) midi_due_q.push_back(midi_msg(MSG_OFF, sounding_nt, 1'b1));
        sounding    = 1'b0;
        sounding_nt = 0;
      end
      return;
    end
    deg = code - 1;
    nt  = base_nt + ScaleSemis[deg % 7] + 12 * (deg / 7)
        + (keys[4] ? 0 : 1) - (keys[6] ? 0 : 1);
    nt  = clampi(nt, 0, 127);
    if (sounding && nt == sounding_nt) return;
    if (sounding && keep) midi_due_q.push_back(midi_msg(MSG_OFF, sounding_nt, 1'b0));
    sounding    = 1'b1;
    sounding_nt = nt;
    if (keep) midi_due_q.push_back(midi_msg(MSG_ON, nt, 1'b1));
  endtask

  // offer one request, idling at random first, and wait until it is taken
  task automatic send_sample(input sample_t s, input bit keep);
    while (!no_idle && rnd(0, 99) < 16) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    func_i          <= s.fn;
    channel_i       <= ChW'(s.ch);
    off_before_mv_i <= MvW'(s.bef);
    lit_mv_i        <= MvW'(s.lit);
    off_after_mv_i  <= MvW'(s.aft);
    frame_end_i     <= s.fend;
    do @(posedge clk_i); while (full);
    track_sample(s, keep);
    sent++;
  endtask

  // readings that give the wanted reflect level, with random dark level,
  // uneven dark pair and odd sums that round away
  function automatic sample_t level_sample(input func_e fn, input int ch,
                                           input int lvl, input bit fend);
    sample_t s;
    int t, dark, spread, tmp;
    t      = clampi(lvl, -3300, 3300);
    dark   = (t >= 0) ? rnd(t, 3300) : rnd(0, 3300 + t);
    spread = (rnd(0, 1) == 0) ? 0 : rnd(0, (dark < 3300 - dark) ? dark : 3300 - dark);
    s.fn   = fn;
    s.ch   = ch;
    s.fend = fend;
    s.lit  = dark - t;
    s.bef  = dark + spread;
    s.aft  = dark - spread;
    if (rnd(0, 1) == 1 && s.aft < 3300 && spread == 0) s.aft++;
    if (rnd(0, 1) == 1) begin
      tmp   = s.bef;
      s.bef = s.aft;
      s.aft = tmp;
    end
    return s;
  endfunction

  // reflect level for a measure request, aimed around the thresholds
  function automatic int key_level(input int ch);
    case (rnd(0, 9))
      0, 1, 2: return base_lvl[ch] + thr_on + 1 + rnd(0, 300);
      3, 4, 5: return base_lvl[ch] + thr_off - 1 - rnd(0, 300);
      6:       return base_lvl[ch] + thr_on;
      7:       return base_lvl[ch] + thr_off;
      8:       return base_lvl[ch] + rnd(0, thr_on > thr_off ? thr_on : thr_off);
      default: return rnd(-3300, 3300);
    endcase
  endfunction

  // random frames until the phase has sent its share of requests
  task automatic run_phase(input int budget);
    int      stop_at, pick, ch, lvl;
    func_e   fn;
    sample_t s;
    int      chans [$];
    stop_at = sent + budget;
    while (sent < stop_at) begin
      chans.delete();
      pick = rnd(0, 99);
      if (pick < 85) begin
        // well-formed frame: measure below 60, calibration above
        if (rnd(0, 99) < 75) begin
          for (int c = 0; c < 8; c++) if (rnd(0, 99) < 70) chans.push_back(c);
        end else begin
          repeat (rnd(1, 8)) chans.push_back(rnd(0, 7));
        end
        if (chans.size() == 0) chans.push_back(7);
        for (int i = 0; i < chans.size(); i++) begin
          if (pick < 60 && rnd(0, 99) >= 6) begin
            fn  = FN_MEASURE;
            lvl = key_level(chans[i]);
          end else begin
            fn  = FN_CAL;
            lvl = (rnd(0, 9) == 0) ? rnd(-3300, 3300) : rnd(-300, 300);
          end
          send_sample(level_sample(fn, chans[i], lvl, i == chans.size() - 1), 1'b1);
        end
      end else if (pick < 88) begin
        // one channel hammered in a single calibration frame: sum saturates
        ch  = rnd(0, 7);
        lvl = (rnd(0, 1) == 1) ? 3300 : -3300;
        for (int i = 0; i < 21; i++)
          send_sample(level_sample(FN_CAL, ch, lvl, i == 20), 1'b1);
      end else begin
        // noise: every field at random
        repeat (rnd(1, 4)) begin
          s.fn   = (rnd(0, 1) == 1) ? FN_CAL : FN_MEASURE;
          s.ch   = rnd(0, 7);
          s.bef  = rnd(0, 3300);
          s.lit  = rnd(0, 3300);
          s.aft  = rnd(0, 3300);
          s.fend = rnd(0, 1);
          send_sample(s, 1'b1);
        end
      end
    end
  endtask

  // drain, let the pipeline empty, then load all six registers
  task automatic reconfigure(input int on_v, input int off_v, input int bn,
                             input int vel, input int ch, input int mask);
    int               vals [6];
    logic [CfgIdxW-1:0] idx [6];
    vals = '{on_v, off_v, bn, vel, ch, mask};
    idx  = '{CFG_ON_THR, CFG_OFF_THR, CFG_BASE_NOTE, CFG_VELOCITY, CFG_MIDI_CH,
             CFG_DET_MASK};
    push <= 1'b0;
    while (midi_due_q.size() != 0) @(posedge clk_i);
    // requests with no message may still sit in the three-stage front
    repeat (16) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= CfgDataW'(vals[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_on   = on_v;
    thr_off  = off_v;
    base_nt  = bn;
    vel_cfg  = vel;
    mchan    = ch;
    det_mask = mask;
  endtask

  // request side: reset, directed table, then configuration phases
  initial begin
    row_t rw;
    msg_t typed_msg;
    thr_on   = int'(RST_ON_THR);
    thr_off  = int'(RST_OFF_THR);
    base_nt  = int'(RST_BASE_NOTE);
    vel_cfg  = int'(RST_VELOCITY);
    mchan    = int'(RST_MIDI_CH);
    det_mask = int'(RST_DET_MASK);
    keys     = '0;
    for (int i = 0; i < 8; i++) begin
      base_lvl[i] = 0;
      cal_acc[i]  = 0;
    end
    cal_frames_seen = 0;
    sounding        = 1'b0;
    sounding_nt     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: typed rows queue their own message, the rest the tracker's
    for (int i = 0; i < NumRows; i++) begin
      rw = StimTable[i];
      send_sample(rw.s, !rw.typed);
      if (rw.typed && rw.n != 0) begin
        typed_msg.kind  = rw.kind;
        typed_msg.chan  = int'(RST_MIDI_CH);
        typed_msg.note  = rw.note;
        typed_msg.vel   = (rw.kind == MSG_ON) ? int'(RST_VELOCITY) : 0;
        typed_msg.flags = rw.flags;
        typed_msg.last  = 1'b1;
        midi_due_q.push_back(typed_msg);
      end
    end
    run_phase(220);

    // thresholds out of reach: keys only ever turn off
    reconfigure(6600, 6600, 127, 127, 15, 255);
    run_phase(200);
    // zero thresholds, lowest note so flats clamp at zero, silent note-on
    reconfigure(0, 0, 0, 0, 1, 255);
    run_phase(220);
    // overlapping thresholds, top note so sharps clamp, half the channels live
    reconfigure(100, 300, 127, 1, 9, 'hAA);
    run_phase(220);
    // detection masked off: keys frozen where they stand
    reconfigure(400, 200, 30, 64, 3, 0);
    run_phase(160);
    // defaults again while the result side stalls and the block backs up
    reconfigure(250, 150, 60, 100, 0, 255);
    hold_req = 1'b1;
    run_phase(260);
    // random settings with both sides running flat out
    reconfigure(rnd(0, 1500), rnd(0, 1500), rnd(0, 127), rnd(0, 127), rnd(0, 15),
                rnd(0, 255));
    no_idle = 1'b1;
    run_phase(250);
    no_idle = 1'b0;
    reconfigure(rnd(0, 6600), rnd(0, 6600), rnd(0, 127), rnd(0, 127), rnd(0, 15),
                rnd(0, 255));
    run_phase(400);

    push <= 1'b0;
    while (midi_due_q.size() != 0) @(posedge clk_i);
    // catch any stray message behind the last one
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result side: random pops, one long stall on request, field checks
  initial begin
    int   hold_left;
    msg_t want;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (midi_due_q.size() == 0) begin
          $display("%0t: unexpected midi request, note %0d", $time, note_o);
          mismatches++;
        end else begin
          want = midi_due_q.pop_front();
          check_field("event_kind", int'(want.kind), int'(event_kind_o));
          check_field("out_channel", want.chan, int'(out_channel_o));
          check_field("note", want.note, int'(note_o));
          check_field("velocity", want.vel, int'(velocity_o));
          check_field("key_flags", want.flags, int'(key_flags_o));
          check_field("last", int'(want.last), int'(last_o));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || rnd(0, 99) >= 16;
      end
    end
  end

  // watchdog: any handshake or register write restarts the count
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
design/rfk_pkg.sv
design/rfk_front.sv
design/rfk_fifo.sv
design/rfk_back.sv
design/reflect_finger_keys_to_midi_note.sv
dv/testbench.sv
